/* hdl/evs_pkg.sv */
// shared constants and types for the energy voice activity segmenter
`timescale 1ns / 1ps
`default_nettype none

package evs_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS    = 16;
  localparam int FRAME_LEN_BITS = 12;
  localparam int THRESH_BITS    = 16;
  localparam int OUT_BITS       = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // defaults for the top level parameters
  localparam int MAX_FRAME_DEF  = 2048;
  localparam int INDEX_BITS_DEF = 32;

  // queue depths, powers of two
  localparam int EVQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  // register reset values
  localparam logic [FRAME_LEN_BITS-1:0] FRAME_LEN_RESET = 12'd160;
  localparam logic [THRESH_BITS-1:0]    THRESH_RESET    = 16'd328;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_LENGTH     = 2'd0,
    REG_ENERGY_THRESHOLD = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

/* hdl/energy_voice_activity_segmenter.sv */
// top level of the energy voice activity segmenter
//
//   channel   handshake              payload
//   input     push / full            sample, last_sample
//   result    empty / pop            segment_start, segment_end
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one sample is taken every cycle while full is low; the front end accumulates and the back
// end does the loudness multiply and compare, one frame-end word per cycle while the result
// queue has room. a result reaches the result ports through the event queue and then the result queue.
// reset is synchronous and clears all frame and segment state and the queues.
// full rises only when the two-word event queue fills, which happens when
// the result queue is full and pop is held low.
`timescale 1ns / 1ps
`default_nettype none

module energy_voice_activity_segmenter #(
  parameter int MAX_FRAME  = evs_pkg::MAX_FRAME_DEF,
  parameter int INDEX_BITS = evs_pkg::INDEX_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [evs_pkg::SAMPLE_BITS-1:0]     sample,
  input  wire logic                                last_sample,
  input  wire logic                                push,
  output logic                                     full,
  output logic [evs_pkg::OUT_BITS-1:0]             segment_start,
  output logic [evs_pkg::OUT_BITS-1:0]             segment_end,
  output logic                                     empty,
  input  wire logic                                pop,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [evs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [evs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int SUM_BITS  = $clog2(MAX_FRAME) + evs_pkg::SAMPLE_BITS;
  localparam int FILL_BITS = $clog2(MAX_FRAME + 1);
  localparam int EVT_BITS  = SUM_BITS + FILL_BITS + 2 * INDEX_BITS + 1;
  localparam int RES_BITS  = 2 * evs_pkg::OUT_BITS;

  logic [evs_pkg::FRAME_LEN_BITS-1:0] frame_length;
  logic [evs_pkg::THRESH_BITS-1:0]    energy_threshold;

  logic                evt_push;
  logic [EVT_BITS-1:0] evt_wr_data;
  logic                evt_full;
  logic                evt_pop;
  logic [EVT_BITS-1:0] evt_rd_data;
  logic                evt_empty;
  logic                res_push;
  logic [RES_BITS-1:0] res_wr_data;
  logic                res_full;
  logic [RES_BITS-1:0] res_rd_data;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length     <= evs_pkg::FRAME_LEN_RESET;
      energy_threshold <= evs_pkg::THRESH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        evs_pkg::REG_FRAME_LENGTH: begin
          frame_length <= cfg_data[evs_pkg::FRAME_LEN_BITS-1:0];
        end
        evs_pkg::REG_ENERGY_THRESHOLD: begin
          energy_threshold <= cfg_data[evs_pkg::THRESH_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // front end
  evs_front #(
    .MAX_FRAME  (MAX_FRAME),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .last_sample  (last_sample),
    .push         (push),
    .full         (full),
    .frame_length (frame_length),
    .evt_push     (evt_push),
    .evt_data     (evt_wr_data),
    .evt_full     (evt_full)
  );

  // frame-end event queue
  evs_fifo #(
    .WIDTH (EVT_BITS),
    .DEPTH (evs_pkg::EVQ_DEPTH)
  ) u_evq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (evt_push),
    .wr_data (evt_wr_data),
    .full    (evt_full),
    .rd_en   (evt_pop),
    .rd_data (evt_rd_data),
    .empty   (evt_empty)
  );

  // back end
  evs_back #(
    .MAX_FRAME  (MAX_FRAME),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .energy_threshold (energy_threshold),
    .evt_data         (evt_rd_data),
    .evt_empty        (evt_empty),
    .evt_pop          (evt_pop),
    .res_push         (res_push),
    .res_data         (res_wr_data),
    .res_full         (res_full)
  );

  // result queue
  evs_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (evs_pkg::RESQ_DEPTH)
  ) u_resq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_wr_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd_data),
    .empty   (empty)
  );

  assign {segment_start, segment_end} = res_rd_data;

endmodule

`default_nettype wire

/* hdl/evs_fifo.sv */
// small first-in first-out queue built from registers
`timescale 1ns / 1ps
`default_nettype none

module evs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_wr;
  logic                do_rd;

  // status
  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr & ~do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd & ~do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/evs_front.sv */
// front end: sample magnitude, frame accumulation and frame-end events
`timescale 1ns / 1ps
`default_nettype none

module evs_front #(
  parameter int MAX_FRAME  = evs_pkg::MAX_FRAME_DEF,
  parameter int INDEX_BITS = evs_pkg::INDEX_BITS_DEF,
  localparam int SUM_BITS  = $clog2(MAX_FRAME) + evs_pkg::SAMPLE_BITS,
  localparam int FILL_BITS = $clog2(MAX_FRAME + 1),
  localparam int EVT_BITS  = SUM_BITS + FILL_BITS + 2 * INDEX_BITS + 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [evs_pkg::SAMPLE_BITS-1:0]     sample,
  input  wire logic                                last_sample,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [evs_pkg::FRAME_LEN_BITS-1:0]  frame_length,
  output logic                                     evt_push,
  output logic [EVT_BITS-1:0]                      evt_data,
  input  wire logic                                evt_full
);

  localparam int LEN_BITS = (FILL_BITS > evs_pkg::FRAME_LEN_BITS) ?
                            FILL_BITS : evs_pkg::FRAME_LEN_BITS;

  logic [SUM_BITS-1:0]             frame_sum;
  logic [FILL_BITS-1:0]            frame_fill;
  logic [INDEX_BITS-1:0]           sample_index;
  logic [INDEX_BITS-1:0]           frame_start_index;

  logic                            accept;
  logic [evs_pkg::SAMPLE_BITS-1:0] mag;
  logic [SUM_BITS-1:0]             sum_next;
  logic [FILL_BITS-1:0]            fill_next;
  logic [INDEX_BITS-1:0]           index_next;
  logic [LEN_BITS-1:0]             len_raw;
  logic [LEN_BITS-1:0]             len_eff;
  logic                            frame_done;

  // a sample waits while the event queue has no room
  assign full   = evt_full;
  assign accept = push & ~evt_full;

  // magnitude of the two's complement sample, 0 to 32768
  assign mag = sample[evs_pkg::SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

  // effective frame length: zero reads as one, clamp at the maximum
  assign len_raw = LEN_BITS'(frame_length);
  always_comb begin
    priority if (len_raw == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (len_raw > LEN_BITS'(MAX_FRAME)) begin
      len_eff = LEN_BITS'(MAX_FRAME);
    end else begin
      len_eff = len_raw;
    end
  end

  // running values including this sample
  assign sum_next   = frame_sum + SUM_BITS'(mag);
  assign fill_next  = frame_fill + 1'b1;
  assign index_next = (&sample_index) ? sample_index : sample_index + 1'b1;
  assign frame_done = (LEN_BITS'(fill_next) >= len_eff) | last_sample;

  // frame-end word for the back end
  assign evt_push = accept & frame_done;
  assign evt_data = {sum_next, fill_next, frame_start_index, index_next, last_sample};

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sum         <= '0;
      frame_fill        <= '0;
      sample_index      <= '0;
      frame_start_index <= '0;
    end else if (accept) begin
      if (last_sample) begin
        frame_sum         <= '0;
        frame_fill        <= '0;
        sample_index      <= '0;
        frame_start_index <= '0;
      end else if (frame_done) begin
        frame_sum         <= '0;
        frame_fill        <= '0;
        sample_index      <= index_next;
        frame_start_index <= index_next;
      end else begin
        frame_sum    <= sum_next;
        frame_fill   <= fill_next;
        sample_index <= index_next;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/evs_back.sv */
// back end: loudness test per frame and speech segment tracking
`timescale 1ns / 1ps
`default_nettype none

module evs_back #(
  parameter int MAX_FRAME  = evs_pkg::MAX_FRAME_DEF,
  parameter int INDEX_BITS = evs_pkg::INDEX_BITS_DEF,
  localparam int SUM_BITS  = $clog2(MAX_FRAME) + evs_pkg::SAMPLE_BITS,
  localparam int FILL_BITS = $clog2(MAX_FRAME + 1),
  localparam int EVT_BITS  = SUM_BITS + FILL_BITS + 2 * INDEX_BITS + 1,
  localparam int RES_BITS  = 2 * evs_pkg::OUT_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [evs_pkg::THRESH_BITS-1:0]  energy_threshold,
  input  wire logic [EVT_BITS-1:0]              evt_data,
  input  wire logic                             evt_empty,
  output logic                                  evt_pop,
  output logic                                  res_push,
  output logic [RES_BITS-1:0]                   res_data,
  input  wire logic                             res_full
);

  localparam int PROD_BITS = evs_pkg::THRESH_BITS + FILL_BITS;
  localparam int CMP_BITS  = (PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS;

  logic                  speech_open;
  logic [INDEX_BITS-1:0] open_segment_start;
  logic                  speech_open_next;
  logic [INDEX_BITS-1:0] open_segment_start_next;

  logic [SUM_BITS-1:0]   e_sum;
  logic [FILL_BITS-1:0]  e_fill;
  logic [INDEX_BITS-1:0] e_start;
  logic [INDEX_BITS-1:0] e_index;
  logic                  e_last;
  logic [PROD_BITS-1:0]  limit;
  logic                  loud;
  logic                  go;
  logic                  emit;
  logic [INDEX_BITS-1:0] seg_lo;
  logic [INDEX_BITS-1:0] seg_hi;

  // unpack the frame-end word
  assign {e_sum, e_fill, e_start, e_index, e_last} = evt_data;

  // take a word only when a result could be queued
  assign go      = ~evt_empty & ~res_full;
  assign evt_pop = go;

  // mean above threshold, tested as sum against threshold times fill
  assign limit = PROD_BITS'(energy_threshold) * PROD_BITS'(e_fill);
  assign loud  = CMP_BITS'(e_sum) > CMP_BITS'(limit);

  // segment tracking
  always_comb begin
    speech_open_next        = speech_open;
    open_segment_start_next = open_segment_start;
    emit                    = 1'b0;
    seg_lo                  = open_segment_start;
    seg_hi                  = e_start;
    if (loud && !speech_open) begin
      speech_open_next        = 1'b1;
      open_segment_start_next = e_start;
    end else if (!loud && speech_open) begin
      speech_open_next = 1'b0;
      emit             = 1'b1;
    end
    // end of buffer closes an open segment at the sample count
    if (e_last) begin
      if (speech_open_next) begin
        emit   = 1'b1;
        seg_lo = open_segment_start_next;
        seg_hi = e_index;
      end
      speech_open_next        = 1'b0;
      open_segment_start_next = '0;
    end
  end

  assign res_push = go & emit;
  assign res_data = {evs_pkg::OUT_BITS'(seg_lo), evs_pkg::OUT_BITS'(seg_hi)};

  // speech state
  always_ff @(posedge clk) begin
    if (rst) begin
      speech_open        <= 1'b0;
      open_segment_start <= '0;
    end else if (go) begin
      speech_open        <= speech_open_next;
      open_segment_start <= open_segment_start_next;
    end
  end

endmodule

`default_nettype wire

/* test/energy_voice_activity_segmenter_tb.sv */
// testbench for the energy voice activity segmenter: predicted segments checked word by word
`timescale 1ns / 1ps

module energy_voice_activity_segmenter_tb;

  localparam int RANDOM_ITEMS = 1650;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 10;
  localparam logic [evs_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
  localparam int MAX_FRAME_SAMPLES = 2048;

  typedef struct packed {
    logic [evs_pkg::OUT_BITS-1:0] start_idx;
    logic [evs_pkg::OUT_BITS-1:0] end_idx;
  } segment_t;

  // scoreboard: frame energy tracker and queue of segments still to come
  class segment_scoreboard;
    logic [evs_pkg::FRAME_LEN_BITS-1:0] frame_len_reg;
    logic [evs_pkg::THRESH_BITS-1:0] thresh_reg;
    logic [evs_pkg::OUT_BITS-1:0] samples_seen;
    logic [evs_pkg::OUT_BITS-1:0] frame_origin;
    logic [evs_pkg::OUT_BITS-1:0] open_start;
    int unsigned energy_acc;
    int unsigned fill;
    bit speaking;
    segment_t pending[$];
    int mismatches;
    int checked;
    int taken;

    function new();
      frame_len_reg = evs_pkg::FRAME_LEN_RESET;
      thresh_reg = evs_pkg::THRESH_RESET;
      clear_buffer();
      mismatches = 0;
      checked = 0;
      taken = 0;
    endfunction

    function void clear_buffer();
      samples_seen = '0;
      frame_origin = '0;
      open_start = '0;
      energy_acc = 0;
      fill = 0;
      speaking = 1'b0;
    endfunction

    function void write_reg(logic [evs_pkg::CFG_INDEX_BITS-1:0] idx,
                            logic [evs_pkg::CFG_DATA_BITS-1:0] data);
      if (idx == evs_pkg::REG_FRAME_LENGTH) begin
        frame_len_reg = data[evs_pkg::FRAME_LEN_BITS-1:0];
      end else if (idx == evs_pkg::REG_ENERGY_THRESHOLD) begin
        thresh_reg = data;
      end
    endfunction

    // note an accepted sample and queue the segment it closes, if any
    function void note_sample(logic signed [evs_pkg::SAMPLE_BITS-1:0] s, bit last);
      int unsigned mag;
      int unsigned eff_len;
      bit loud;
      segment_t seg;
      mag = (s < 0) ? int'(-int'(s)) : int'(s);
      eff_len = (frame_len_reg == 0) ? 1 : int'(frame_len_reg);
      if (eff_len > MAX_FRAME_SAMPLES) begin
        eff_len = MAX_FRAME_SAMPLES;
      end
      taken++;
      energy_acc += mag;
      fill++;
      if (samples_seen != '1) begin
        samples_seen++;
      end
      // frame close and loudness decision
      if (fill >= eff_len || last) begin
        loud = longint'(energy_acc) > longint'(thresh_reg) * longint'(fill);
        if (loud && !speaking) begin
          speaking = 1'b1;
          open_start = frame_origin;
        end else if (!loud && speaking) begin
          speaking = 1'b0;
          seg.start_idx = open_start;
          seg.end_idx = frame_origin;
          pending.insert(pending.size(), seg);
        end
        energy_acc = 0;
        fill = 0;
        frame_origin = samples_seen;
      end
      // end of buffer closes an open segment
      if (last) begin
        if (speaking) begin
          seg.start_idx = open_start;
          seg.end_idx = samples_seen;
          pending.insert(pending.size(), seg);
        end
        clear_buffer();
      end
    endfunction

    function void check_segment(logic [evs_pkg::OUT_BITS-1:0] st,
                                logic [evs_pkg::OUT_BITS-1:0] en);
      segment_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected segment start %0d end %0d", st, en);
        end
      end else begin
        want = pending.pop_front();
        if (st !== want.start_idx) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("segment_start: expected %0d, got %0d", want.start_idx, st);
          end
        end
        if (en !== want.end_idx) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("segment_end: expected %0d, got %0d", want.end_idx, en);
          end
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [evs_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic last_sample = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [evs_pkg::OUT_BITS-1:0] segment_start;
  logic [evs_pkg::OUT_BITS-1:0] segment_end;
  logic empty;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [evs_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [evs_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  segment_scoreboard sb;
  int burst_left = 0;
  int random_sent = 0;
  int cfg_writes = 0;
  int phase_count = 0;
  int cur_eff = 160;
  int unsigned cur_thr = 328;
  int idle_cycles = 0;
  int pace_mode = 0;
  int pace_left = 0;

  energy_voice_activity_segmenter dut (
    .clk(clk),
    .rst(rst),
    .sample(sample),
    .last_sample(last_sample),
    .push(push),
    .full(full),
    .segment_start(segment_start),
    .segment_end(segment_end),
    .empty(empty),
    .pop(pop),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // result side: check each popped word, pop on a changing stall pattern
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      sb.check_segment(segment_start, segment_end);
    end
    if (pace_left == 0) begin
      pace_mode <= $urandom_range(0, 2);
      pace_left <= $urandom_range(16, 200);
    end else begin
      pace_left <= pace_left - 1;
    end
    case (pace_mode)
      0: begin
        pop <= !rst;
      end
      1: begin
        pop <= !rst && ($urandom_range(0, 1) == 1);
      end
      default: begin
        pop <= !rst && ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // sample with magnitude above or at most the threshold, now and then pure noise
  function automatic logic [evs_pkg::SAMPLE_BITS-1:0] pick_sample(bit loud, int unsigned thr);
    int unsigned mag;
    if ($urandom_range(0, 7) == 0) begin
      return 16'($urandom);
    end
    if (loud && thr < 32768) begin
      mag = $urandom_range(thr + 1, 32768);
    end else if (loud) begin
      mag = $urandom_range(0, 32768);
    end else begin
      mag = $urandom_range(0, (thr > 32768) ? 32768 : thr);
    end
    if (mag == 32768) begin
      return 16'h8000;
    end
    return ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
  endfunction

  // push one word, then either carry on the burst or take a gap
  task automatic send_sample(input logic [evs_pkg::SAMPLE_BITS-1:0] s, input bit last);
    int gap;
    sample <= s;
    last_sample <= last;
    push <= 1'b1;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    sb.note_sample(s, last);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 2);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off until every expected segment is out, then let the pipeline settle
  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes back to back, valid held high across them
  task automatic program_regs(input logic [evs_pkg::FRAME_LEN_BITS-1:0] fl,
                              input logic [evs_pkg::THRESH_BITS-1:0] thr,
                              input bit poke_spare);
    logic [evs_pkg::CFG_INDEX_BITS-1:0] widx;
    logic [evs_pkg::CFG_DATA_BITS-1:0] wdata;
    for (int k = 0; k < (poke_spare ? 3 : 2); k++) begin
      case (k)
        0: begin
          widx = evs_pkg::REG_FRAME_LENGTH;
          wdata = {4'($urandom), fl};
        end
        1: begin
          widx = evs_pkg::REG_ENERGY_THRESHOLD;
          wdata = thr;
        end
        default: begin
          widx = REG_SPARE;
          wdata = 16'($urandom);
        end
      endcase
      cfg_index <= widx;
      cfg_data <= wdata;
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) begin
        @(posedge clk);
      end
      sb.write_reg(widx, wdata);
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
    cur_eff = (fl == 0) ? 1 : ((fl > MAX_FRAME_SAMPLES) ? MAX_FRAME_SAMPLES : int'(fl));
    cur_thr = thr;
  endtask

  // a run of frames, each loud or quiet; the last may be short and end the buffer
  task automatic send_buffer(input int n_frames, input bit close, input bit staged);
    bit loud;
    int len;
    bool_tail: for (int f = 0; f < n_frames; f++) begin
      loud = staged ? (f == 0) : ($urandom_range(0, 1) == 1);
      len = cur_eff;
      if (close && f == n_frames - 1) begin
        len = $urandom_range(1, (cur_eff > 256) ? 64 : cur_eff);
      end
      for (int i = 0; i < len; i++) begin
        send_sample(pick_sample(loud, cur_thr), close && f == n_frames - 1 && i == len - 1);
        random_sent++;
      end
    end
  endtask

  initial begin
    logic [evs_pkg::FRAME_LEN_BITS-1:0] fl;
    logic [evs_pkg::THRESH_BITS-1:0] thr;
    int target;
    int first;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: equality at threshold, full scale, short last frames
    program_regs(12'd4, 16'd100, 1'b1);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'sd101, 1'b0);
    send_sample(-16'sd101, 1'b0);
    repeat (4) send_sample(16'sd0, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'sd0, 1'b1);
    repeat (4) send_sample(16'sd500, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b1);

    // random phases, each under its own register setting
    while (random_sent < RANDOM_ITEMS) begin
      case (phase_count)
        0: begin
          fl = 12'd160;
          thr = 16'd328;
        end
        1: begin
          fl = 12'd0;
          thr = 16'd0;
        end
        2: begin
          fl = 12'd4095;
          thr = 16'd20000;
        end
        3: begin
          fl = 12'd1;
          thr = 16'd65535;
        end
        4: begin
          fl = 12'd2048;
          thr = 16'd32768;
        end
        default: begin
          case ($urandom_range(0, 9))
            0: fl = 12'd0;
            1: fl = 12'd1;
            2: fl = 12'($urandom_range(100, 200));
            default: fl = 12'($urandom_range(2, 24));
          endcase
          case ($urandom_range(0, 9))
            0: thr = 16'd0;
            1: thr = 16'd32768;
            2: thr = 16'($urandom_range(32769, 65535));
            3: thr = 16'($urandom_range(20000, 32767));
            default: thr = 16'($urandom_range(1, 3000));
          endcase
        end
      endcase
      drain();
      program_regs(fl, thr, 1'b0);
      target = $urandom_range(40, 200);
      first = random_sent;
      while (random_sent - first < target) begin
        if (cur_eff > 256) begin
          send_buffer(1, 1'b1, 1'b0);
        end else begin
          send_buffer($urandom_range(1, (cur_eff <= 24) ? 12 : 2),
                      $urandom_range(0, 3) != 0, 1'b0);
        end
        if ($urandom_range(0, 15) == 0) begin
          drain();
        end
      end
      phase_count++;
    end

    drain();
    $display("covered %0d samples over %0d register settings, %0d register writes",
             sb.taken, phase_count + 1, cfg_writes);
    $display("%0d segment words compared, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/evs_pkg.sv
hdl/evs_fifo.sv
hdl/evs_front.sv
hdl/evs_back.sv
hdl/energy_voice_activity_segmenter.sv
test/energy_voice_activity_segmenter_tb.sv
